[rtl/icns_best_png_chunk_finder_unit_assert.svh]
// Assertion macros for the ICNS chunk finder.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef ICNS_BEST_PNG_CHUNK_FINDER_UNIT_ASSERT_SVH
`define ICNS_BEST_PNG_CHUNK_FINDER_UNIT_ASSERT_SVH

// Same-cycle implication
`define ICNSBP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icnsbp: same-cycle check failed");

// Next-cycle implication
`define ICNSBP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icnsbp: next-cycle check failed");

`endif

[rtl/icnsbp_pkg.sv]
// Shared types, codes and tag tables for the ICNS chunk finder.
// No dependencies.
`timescale 1ns / 1ps

package icnsbp_pkg;

    // Walk phases
    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_BAD  = 3'd1,
        PH_CHDR = 3'd2,
        PH_PAY  = 3'd3,
        PH_STOP = 3'd4
    } phase_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_SHORT  = 2'd1,
        ST_NONE   = 2'd2,
        ST_BADSIG = 2'd3
    } status_t;

    // One result item
    typedef struct packed {
        status_t     status;
        logic [31:0] offset;
        logic [31:0] size;
        logic [2:0]  prio;
    } result_t;

    localparam logic [31:0] MAGIC_ICNS    = 32'h6963_6E73;
    localparam int          FILE_HDR_LEN  = 8;
    localparam int          CHUNK_HDR_LEN = 8;
    localparam logic [3:0]  NO_PRIO       = 4'd8;
    // start (up to 32 bits) + chunk size (32 bits) + header, without overflow
    localparam int          SUM_W         = 34;

    // PNG tags in priority order, 0 is best
    localparam logic [31:0] PNG_TAGS [8] = '{
        32'h6963_3130, 32'h6963_3134, 32'h6963_3039, 32'h6963_3133,
        32'h6963_3038, 32'h6963_3132, 32'h6963_3037, 32'h6963_3131
    };

    // PNG signature, first four bytes
    localparam logic [7:0] PNG_SIG [4] = '{8'h89, 8'h50, 8'h4E, 8'h47};

    // Returns {hit, priority} for a chunk tag
    function automatic logic [3:0] tag_match(input logic [31:0] tag);
        logic [3:0] res;
        res = '0;
        for (int i = 7; i >= 0; i--) begin
            if (PNG_TAGS[i] == tag) begin
                res = {1'b1, 3'(i)};
            end
        end
        return res;
    endfunction

endpackage

[rtl/icns_best_png_chunk_finder_unit.sv]
// Top level of the ICNS best-PNG chunk finder: byte walker and result logic.
// Depends on icnsbp_pkg, icnsbp_result and the assertion macro header.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in      | in  | in_valid / in_stall  | data_byte, last_byte
//  out     | out | out_valid / out_stall| status, data_offset, data_size, chosen_priority
//
// One byte per cycle while in_stall is low; the walker state updates at the transfer edge and the
// result appears in the output register in the cycle after the final byte.
// in_stall rises only for a final byte while an earlier result is held.
// Reset (async, active low) starts a new file; a final byte does the same.
// No clearing pass: all state is in flip-flops.
`timescale 1ns / 1ps
`include "icns_best_png_chunk_finder_unit_assert.svh"

module icns_best_png_chunk_finder_unit #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] data_offset,
    output logic [31:0] data_size,
    output logic [2:0]  chosen_priority
);
    import icnsbp_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX   = '1;
    localparam logic [31:0]             OFF_MAX32 = 32'(OFF_MAX);

    // state
    phase_t                  phase_reg, phase_next, phase_walk;
    logic [2:0]              sub_cnt_reg, sub_cnt_next;
    logic [31:0]             hdr_word_reg, hdr_word_next;
    logic [OFFSET_WIDTH-1:0] end_limit_reg, end_limit_next;
    logic [OFFSET_WIDTH-1:0] chunk_start_reg, chunk_start_next;
    logic [OFFSET_WIDTH-1:0] chunk_end_reg, chunk_end_next;
    logic                    cont_ok_reg, cont_ok_next;
    logic [OFFSET_WIDTH-1:0] pay_len_reg, pay_len_next;
    logic [OFFSET_WIDTH-1:0] pay_left_reg, pay_left_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic                    pend_sig_reg, pend_sig_next;
    logic [2:0]              pend_prio_reg, pend_prio_next;
    logic [3:0]              best_prio_reg, best_prio_next;
    logic [OFFSET_WIDTH-1:0] best_offset_reg, best_offset_next;
    logic [OFFSET_WIDTH-1:0] best_len_reg, best_len_next;
    logic                    best_sig_reg, best_sig_next;

    // decode
    logic                    accept;
    logic [31:0]             word;
    logic [OFFSET_WIDTH-1:0] limit_val;
    logic                    first_ok;
    logic                    hdr_bad, hdr_done;
    logic                    tag_step, size_step, size_bad;
    logic [3:0]              tag_res;
    logic [SUM_W-1:0]        sum_end, sum_cont;
    logic                    cont_now;
    logic                    pend_keep;
    logic                    sig_clr, pend_sig_cur;
    logic                    fin_size, pay_last, fin;
    logic                    fin_valid, fin_sig, fin_cont, fin_stop;
    logic [OFFSET_WIDTH-1:0] fin_len, fin_end, start8;
    logic                    best_upd;
    logic [3:0]              best_prio_w;
    logic [OFFSET_WIDTH-1:0] best_offset_w, best_len_w;
    logic                    best_sig_w;
    logic                    short_file;
    result_t                 res;

    // a final byte needs room in the output register
    assign in_stall = out_valid && out_stall && last_byte;
    assign accept   = in_valid && !in_stall;

    // byte decode
    always_comb
    begin
        word      = {hdr_word_reg[23:0], data_byte};
        limit_val = (word > OFF_MAX32) ? OFF_MAX : word[OFFSET_WIDTH-1:0];
        first_ok  = limit_val >= OFFSET_WIDTH'(FILE_HDR_LEN + CHUNK_HDR_LEN);
        hdr_bad   = (phase_reg == PH_HDR) && (sub_cnt_reg == 3'd3) && (word != MAGIC_ICNS);
        hdr_done  = (phase_reg == PH_HDR) && (sub_cnt_reg == 3'd7);
        tag_step  = (phase_reg == PH_CHDR) && (sub_cnt_reg == 3'd3);
        size_step = (phase_reg == PH_CHDR) && (sub_cnt_reg == 3'd7);
        tag_res   = tag_match(word);

        // chunk bounds against the declared size
        sum_end   = SUM_W'(chunk_start_reg) + SUM_W'(word);
        sum_cont  = sum_end + SUM_W'(CHUNK_HDR_LEN);
        cont_now  = sum_cont <= SUM_W'(end_limit_reg);
        size_bad  = (word < 32'(CHUNK_HDR_LEN)) || (sum_end > SUM_W'(end_limit_reg));
        pend_keep = pend_valid_reg && ({1'b0, pend_prio_reg} < best_prio_reg);

        // signature check on the first payload bytes
        sig_clr      = (phase_reg == PH_PAY) && !sub_cnt_reg[2] && pend_valid_reg
                       && (data_byte != PNG_SIG[sub_cnt_reg[1:0]]);
        pend_sig_cur = pend_sig_reg && !sig_clr;

        // chunk completion
        fin_size  = size_step && !size_bad && (word == 32'(CHUNK_HDR_LEN));
        pay_last  = (phase_reg == PH_PAY) && (pay_left_reg == OFFSET_WIDTH'(1));
        fin       = fin_size || pay_last;
        fin_valid = fin_size ? pend_keep : pend_valid_reg;
        fin_sig   = fin_size ? pend_sig_reg : pend_sig_cur;
        fin_cont  = fin_size ? cont_now : cont_ok_reg;
        fin_len   = fin_size ? '0 : pay_len_reg;
        fin_end   = fin_size ? sum_end[OFFSET_WIDTH-1:0] : chunk_end_reg;
        fin_stop  = fin && ((fin_valid && (pend_prio_reg == 3'd0)) || !fin_cont);
        start8    = chunk_start_reg + OFFSET_WIDTH'(CHUNK_HDR_LEN);
    end

    // next phase
    always_comb
    begin
        phase_walk = phase_reg;
        case (phase_reg)
            PH_HDR:
            begin
                if (hdr_bad)
                begin
                    phase_walk = PH_BAD;
                end
                else if (hdr_done)
                begin
                    phase_walk = first_ok ? PH_CHDR : PH_STOP;
                end
            end
            PH_CHDR:
            begin
                if (size_step)
                begin
                    if (size_bad)
                    begin
                        phase_walk = PH_STOP;
                    end
                    else if (fin_size)
                    begin
                        phase_walk = fin_stop ? PH_STOP : PH_CHDR;
                    end
                    else
                    begin
                        phase_walk = PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                if (pay_last)
                begin
                    phase_walk = fin_stop ? PH_STOP : PH_CHDR;
                end
            end
            default:
            begin
                phase_walk = phase_reg;
            end
        endcase

        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = last_byte ? PH_HDR : phase_walk;
        end
    end

    // best-chunk update at chunk completion
    always_comb
    begin
        best_upd      = fin && fin_valid;
        best_prio_w   = best_upd ? {1'b0, pend_prio_reg} : best_prio_reg;
        best_offset_w = best_upd ? start8 : best_offset_reg;
        best_len_w    = best_upd ? fin_len : best_len_reg;
        best_sig_w    = best_upd ? fin_sig : best_sig_reg;
    end

    // walker datapath
    always_comb
    begin
        sub_cnt_next     = sub_cnt_reg;
        hdr_word_next    = hdr_word_reg;
        end_limit_next   = end_limit_reg;
        chunk_start_next = chunk_start_reg;
        chunk_end_next   = chunk_end_reg;
        cont_ok_next     = cont_ok_reg;
        pay_len_next     = pay_len_reg;
        pay_left_next    = pay_left_reg;
        pend_valid_next  = pend_valid_reg;
        pend_sig_next    = pend_sig_reg;
        pend_prio_next   = pend_prio_reg;
        best_prio_next   = best_prio_reg;
        best_offset_next = best_offset_reg;
        best_len_next    = best_len_reg;
        best_sig_next    = best_sig_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    hdr_word_next = word;
                    sub_cnt_next  = sub_cnt_reg + 3'd1;
                    if (hdr_done)
                    begin
                        end_limit_next   = limit_val;
                        chunk_start_next = OFFSET_WIDTH'(FILE_HDR_LEN);
                        hdr_word_next    = '0;
                    end
                end
                PH_CHDR:
                begin
                    hdr_word_next = word;
                    sub_cnt_next  = sub_cnt_reg + 3'd1;
                    if (tag_step)
                    begin
                        pend_valid_next = tag_res[3];
                        pend_sig_next   = tag_res[3];
                        pend_prio_next  = tag_res[2:0];
                    end
                    else if (size_step)
                    begin
                        if (size_bad)
                        begin
                            pend_valid_next = 1'b0;
                        end
                        else
                        begin
                            chunk_end_next  = sum_end[OFFSET_WIDTH-1:0];
                            cont_ok_next    = cont_now;
                            pay_len_next    = OFFSET_WIDTH'(word - 32'(CHUNK_HDR_LEN));
                            pay_left_next   = OFFSET_WIDTH'(word - 32'(CHUNK_HDR_LEN));
                            pend_valid_next = pend_keep;
                        end
                    end
                end
                PH_PAY:
                begin
                    if (!sub_cnt_reg[2])
                    begin
                        sub_cnt_next = sub_cnt_reg + 3'd1;
                    end
                    pend_sig_next = pend_sig_cur;
                    pay_left_next = pay_left_reg - OFFSET_WIDTH'(1);
                end
                default:
                begin
                    sub_cnt_next = sub_cnt_reg;
                end
            endcase

            // chunk complete: fold candidate, move to next header unless the walk stops
            if (fin)
            begin
                best_prio_next   = best_prio_w;
                best_offset_next = best_offset_w;
                best_len_next    = best_len_w;
                best_sig_next    = best_sig_w;
                pend_valid_next  = 1'b0;
                if (!fin_stop)
                begin
                    chunk_start_next = fin_end;
                    sub_cnt_next     = '0;
                    hdr_word_next    = '0;
                end
            end

            // final byte: back to the start of a file
            if (last_byte)
            begin
                sub_cnt_next     = '0;
                hdr_word_next    = '0;
                end_limit_next   = '0;
                chunk_start_next = OFFSET_WIDTH'(FILE_HDR_LEN);
                pend_valid_next  = 1'b0;
                pend_sig_next    = 1'b0;
                pend_prio_next   = '0;
                best_prio_next   = NO_PRIO;
                best_offset_next = '0;
                best_len_next    = '0;
                best_sig_next    = 1'b0;
            end
        end
    end

    // result of the final byte
    always_comb
    begin
        short_file = (phase_reg == PH_HDR) && (sub_cnt_reg < 3'd7);
        res        = '{status: ST_NONE, offset: '0, size: '0, prio: '0};
        if (short_file || (phase_walk == PH_BAD))
        begin
            res.status = ST_SHORT;
        end
        else if ((best_prio_w >= NO_PRIO) || (best_len_w == '0))
        begin
            res.status = ST_NONE;
        end
        else
        begin
            res.status = ((best_len_w < OFFSET_WIDTH'(8)) || !best_sig_w) ? ST_BADSIG
                                                                           : ST_FOUND;
            res.offset = 32'(best_offset_w);
            res.size   = 32'(best_len_w);
            res.prio   = best_prio_w[2:0];
        end
    end

    // walker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR;
            sub_cnt_reg     <= '0;
            hdr_word_reg    <= '0;
            end_limit_reg   <= '0;
            chunk_start_reg <= OFFSET_WIDTH'(FILE_HDR_LEN);
            chunk_end_reg   <= '0;
            cont_ok_reg     <= 1'b0;
            pay_len_reg     <= '0;
            pay_left_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            pend_sig_reg    <= 1'b0;
            pend_prio_reg   <= '0;
            best_prio_reg   <= NO_PRIO;
            best_offset_reg <= '0;
            best_len_reg    <= '0;
            best_sig_reg    <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            sub_cnt_reg     <= sub_cnt_next;
            hdr_word_reg    <= hdr_word_next;
            end_limit_reg   <= end_limit_next;
            chunk_start_reg <= chunk_start_next;
            chunk_end_reg   <= chunk_end_next;
            cont_ok_reg     <= cont_ok_next;
            pay_len_reg     <= pay_len_next;
            pay_left_reg    <= pay_left_next;
            pend_valid_reg  <= pend_valid_next;
            pend_sig_reg    <= pend_sig_next;
            pend_prio_reg   <= pend_prio_next;
            best_prio_reg   <= best_prio_next;
            best_offset_reg <= best_offset_next;
            best_len_reg    <= best_len_next;
            best_sig_reg    <= best_sig_next;
        end
    end

    // result register
    icnsbp_result u_result (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (accept && last_byte),
        .res             (res),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .data_offset     (data_offset),
        .data_size       (data_size),
        .chosen_priority (chosen_priority)
    );

    // checks
    `ICNSBP_ASSERT_NXT(a_last_loads_result, in_valid && !in_stall && last_byte, out_valid)
    `ICNSBP_ASSERT_NXT(a_restart_after_last, in_valid && !in_stall && last_byte, phase_reg == PH_HDR && best_prio_reg == NO_PRIO)
    `ICNSBP_ASSERT_IMP(a_empty_fields, out_valid && (status == ST_SHORT || status == ST_NONE), data_offset == '0 && data_size == '0 && chosen_priority == '0)

endmodule

[rtl/icnsbp_result.sv]
// Output register for the ICNS chunk finder result channel.
// Depends on icnsbp_pkg (result_t).
`timescale 1ns / 1ps

module icnsbp_result (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  icnsbp_pkg::result_t  res,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [31:0]          data_offset,
    output logic [31:0]          data_size,
    output logic [2:0]           chosen_priority
);
    import icnsbp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // valid holds until the transfer completes, a load refills it
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = valid_reg;
    assign status          = res_reg.status;
    assign data_offset     = res_reg.offset;
    assign data_size       = res_reg.size;
    assign chosen_priority = res_reg.prio;

endmodule
